// ===== design/hrp_pkg.sv =====
// Shared types, codes and constants of the HTTP request header parser.
package hrp_pkg;

  // One input transaction: a request byte and its start-of-request mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [10:0] offset;
    logic [2:0]  part;
    logic [3:0]  event_res;
    logic [1:0]  method;
    logic [4:0]  field_index;
    logic [10:0] content_length;
    logic        last;
  } out_item_t;

  // A request byte with its character classes worked out by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] lower;
    logic [3:0] digit;
    logic       start_req;
    logic       is_space;
    logic       is_lf;
    logic       is_colon;
    logic       is_ws;
    logic       is_digit;
    logic       is_plus;
    logic       is_minus;
  } cls_item_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URI,
    PH_VERSION,
    PH_FIELDS,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    VAL_SKIP,
    VAL_DIGITS,
    VAL_NONE
  } val_stage_t;

  // Part codes.
  localparam logic [2:0] PART_METHOD  = 3'd0;
  localparam logic [2:0] PART_URI     = 3'd1;
  localparam logic [2:0] PART_VERSION = 3'd2;
  localparam logic [2:0] PART_KEY     = 3'd3;
  localparam logic [2:0] PART_VALUE   = 3'd4;
  localparam logic [2:0] PART_BODY    = 3'd5;
  localparam logic [2:0] PART_DELIM   = 3'd6;
  localparam logic [2:0] PART_IGNORED = 3'd7;

  // Event codes.
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_METHOD_END  = 4'd1;
  localparam logic [3:0] EV_URI_END     = 4'd2;
  localparam logic [3:0] EV_VERSION_END = 4'd3;
  localparam logic [3:0] EV_KEY_END     = 4'd4;
  localparam logic [3:0] EV_FIELD_END   = 4'd5;
  localparam logic [3:0] EV_HEADER_END  = 4'd6;
  localparam logic [3:0] EV_BODY_END    = 4'd7;
  localparam logic [3:0] EV_OVERFLOW    = 4'd8;
  localparam logic [3:0] EV_FIELD_LIMIT = 4'd9;

  // Method codes.
  localparam logic [1:0] METH_GET    = 2'd0;
  localparam logic [1:0] METH_POST   = 2'd1;
  localparam logic [1:0] METH_PUT    = 2'd2;
  localparam logic [1:0] METH_DELETE = 2'd3;

  // Method names as they sit in the prefix register, first byte lowest.
  localparam logic [23:0] PFX_GET    = 24'h544547;
  localparam logic [31:0] PFX_POST   = 32'h54534F50;
  localparam logic [23:0] PFX_PUT    = 24'h545550;
  localparam logic [47:0] PFX_DELETE = 48'h4554454C4544;

  // Characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Length of the key name "content-length".
  localparam logic [3:0] NAME_LEN = 4'd14;

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/hrp_fifo.sv =====
// Small register-based FIFO queue; DEPTH must be a power of two, at least 2.
module hrp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/hrp_front.sv =====
// Front end: accepts request bytes and registers them with their character classes.
module hrp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hrp_pkg::in_item_t   in_data,
  output logic                full,
  output logic                q_push,
  output hrp_pkg::cls_item_t  q_data,
  input  logic                q_full
);

  import hrp_pkg::*;

  logic      valid_r, valid_nxt;
  cls_item_t item_r;
  cls_item_t item_nxt;
  logic      accept;
  logic [7:0] b;

  assign b      = in_data.data_byte;
  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_data = item_r;

  always_comb begin
    item_nxt.data_byte = b;
    item_nxt.start_req = in_data.start_req;
    item_nxt.lower     = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
    item_nxt.digit     = b[3:0];
    item_nxt.is_space  = (b == CH_SPACE);
    item_nxt.is_lf     = (b == CH_LF);
    item_nxt.is_colon  = (b == CH_COLON);
    item_nxt.is_ws     = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    item_nxt.is_digit  = (b >= CH_ZERO && b <= CH_NINE);
    item_nxt.is_plus   = (b == CH_PLUS);
    item_nxt.is_minus  = (b == CH_MINUS);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== design/hrp_back.sv =====
// Back end: the parse state machine that tags each classified byte.
module hrp_back #(
  parameter int HEADER_BYTES = 1024,
  parameter int BODY_BYTES   = 1024,
  parameter int MAX_FIELDS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hrp_pkg::cls_item_t  q_data,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                res_full,
  output logic                res_push,
  output hrp_pkg::out_item_t  res_data
);

  import hrp_pkg::*;

  // The offset can run a few bytes past the header limit before the body starts.
  localparam int OFF_W = $clog2(HEADER_BYTES + BODY_BYTES + 16);
  localparam int LEN_W = $clog2(BODY_BYTES + 2);
  localparam int FLD_W = $clog2(MAX_FIELDS + 1);
  localparam int ACC_W = LEN_W + 4;
  localparam logic [3:0] VER_BYTES = 4'd8;

  function automatic logic [1:0] decode_method(input logic [47:0] pfx);
    logic [1:0] m;
    if (pfx[23:0] == PFX_GET) begin
      m = METH_GET;
    end else if (pfx[31:0] == PFX_POST) begin
      m = METH_POST;
    end else if (pfx[23:0] == PFX_PUT) begin
      m = METH_PUT;
    end else if (pfx == PFX_DELETE) begin
      m = METH_DELETE;
    end else begin
      m = METH_GET;
    end
    return m;
  endfunction

  phase_t           phase_r, phase_nxt, cur_phase;
  logic [OFF_W-1:0] off_r, off_nxt, cur_off;
  logic             prev_colon_r, prev_colon_nxt, cur_prev_colon;
  logic [47:0]      prefix_r, prefix_nxt, cur_prefix;
  logic [1:0]       cnt_r, cnt_nxt, cur_cnt;
  logic [FLD_W-1:0] fields_r, fields_nxt, cur_fields;
  logic [3:0]       kpos_r, kpos_nxt, cur_kpos;
  logic             kmatch_r, kmatch_nxt, cur_kmatch;
  logic             found_r, found_nxt, cur_found;
  logic [LEN_W-1:0] acc_r, acc_nxt, cur_acc;
  logic [LEN_W-1:0] body_r, body_nxt, cur_body;
  val_stage_t       vstage_r, vstage_nxt, cur_vstage;
  logic             vneg_r, vneg_nxt, cur_vneg;
  logic             kend_r, kend_nxt, cur_kend;
  logic [3:0]       ver_r, ver_nxt, cur_ver;
  logic [LEN_W-1:0] flen_r, flen_nxt, cur_flen;
  logic [1:0]       meth_r, meth_nxt, cur_meth;

  logic             fire, st;
  logic             hdr_last, meth_end, sep;
  logic [FLD_W-1:0] fields_inc;
  logic [LEN_W-1:0] body_inc;
  logic [LEN_W-1:0] value_res;
  logic [ACC_W-1:0] acc10;
  logic [LEN_W-1:0] acc_step;

  logic [2:0]       part;
  logic [3:0]       ev;
  logic [OFF_W-1:0] out_off;
  logic [OFF_W-1:0] fin_base;
  logic             fin, body_end, go_body, last;

  assign fire     = !q_empty && !res_full;
  assign q_pop    = fire;
  assign res_push = fire;
  assign st       = q_data.start_req;

  // A start mark sees the reset state instead of the registers.
  assign cur_phase      = st ? PH_METHOD : phase_r;
  assign cur_off        = st ? '0 : off_r;
  assign cur_prev_colon = st ? 1'b0 : prev_colon_r;
  assign cur_prefix     = st ? '0 : prefix_r;
  assign cur_cnt        = st ? '0 : cnt_r;
  assign cur_fields     = st ? '0 : fields_r;
  assign cur_kpos       = st ? '0 : kpos_r;
  assign cur_kmatch     = st ? 1'b1 : kmatch_r;
  assign cur_found      = st ? 1'b0 : found_r;
  assign cur_acc        = st ? '0 : acc_r;
  assign cur_body       = st ? '0 : body_r;
  assign cur_vstage     = st ? VAL_NONE : vstage_r;
  assign cur_vneg       = st ? 1'b0 : vneg_r;
  assign cur_kend       = st ? 1'b0 : kend_r;
  assign cur_ver        = st ? '0 : ver_r;
  assign cur_flen       = st ? '0 : flen_r;
  assign cur_meth       = st ? METH_GET : meth_r;

  assign hdr_last   = (cur_off >= OFF_W'(HEADER_BYTES - 1));
  assign meth_end   = (cur_off >= OFF_W'(3)) && q_data.is_space;
  assign sep        = cur_prev_colon && q_data.is_space;
  assign fields_inc = cur_fields + 1'b1;
  assign body_inc   = cur_body + 1'b1;

  // Decimal accumulate; anything past the body size saturates one above it.
  assign acc10    = (ACC_W'(cur_acc) << 3) + (ACC_W'(cur_acc) << 1) + ACC_W'(q_data.digit);
  assign acc_step = (acc10 > ACC_W'(BODY_BYTES)) ? LEN_W'(BODY_BYTES + 1) : LEN_W'(acc10);

  assign value_res = cur_vneg ? '0 :
                     (cur_acc > LEN_W'(BODY_BYTES)) ? LEN_W'(BODY_BYTES) : cur_acc;

  // Output decode: part, event, offset and whether the header finishes here.
  always_comb begin
    part     = PART_IGNORED;
    ev       = EV_NONE;
    out_off  = cur_off;
    fin      = 1'b0;
    fin_base = cur_off + 1'b1;
    body_end = 1'b0;
    case (cur_phase)
      PH_METHOD: begin
        part = PART_METHOD;
        if (meth_end) begin
          part = PART_DELIM;
          ev   = EV_METHOD_END;
        end else if (hdr_last) begin
          ev       = EV_OVERFLOW;
          fin      = 1'b1;
          fin_base = cur_off + OFF_W'(2);
        end
      end
      PH_URI: begin
        part = PART_URI;
        if (q_data.is_space) begin
          part = PART_DELIM;
          ev   = EV_URI_END;
        end else if (hdr_last) begin
          ev       = EV_OVERFLOW;
          fin      = 1'b1;
          fin_base = cur_off + OFF_W'(2);
        end
      end
      PH_VERSION: begin
        part = PART_VERSION;
        if (cur_ver < VER_BYTES) begin
          if (cur_ver == VER_BYTES - 1'b1 && hdr_last) begin
            ev       = EV_OVERFLOW;
            fin      = 1'b1;
            fin_base = cur_off + OFF_W'(3);
          end
        end else if (q_data.is_lf) begin
          part = PART_DELIM;
          ev   = EV_VERSION_END;
          if (hdr_last) begin
            ev       = EV_OVERFLOW;
            fin      = 1'b1;
            fin_base = cur_off + OFF_W'(2);
          end
        end else if (hdr_last) begin
          ev       = EV_OVERFLOW;
          fin      = 1'b1;
          fin_base = cur_off + OFF_W'(3);
        end
      end
      PH_FIELDS: begin
        part = cur_kend ? PART_VALUE : PART_KEY;
        if (q_data.is_lf) begin
          part = PART_DELIM;
          if (cur_cnt != '0) begin
            ev  = EV_HEADER_END;
            fin = 1'b1;
          end else begin
            ev = EV_FIELD_END;
            if (fields_inc >= FLD_W'(MAX_FIELDS)) begin
              ev       = EV_FIELD_LIMIT;
              fin      = 1'b1;
              fin_base = cur_off + OFF_W'(2);
            end else if (hdr_last) begin
              ev       = EV_OVERFLOW;
              fin      = 1'b1;
              fin_base = cur_off + OFF_W'(2);
            end
          end
        end else begin
          if (sep) begin
            part = PART_DELIM;
            ev   = EV_KEY_END;
          end
          if (hdr_last) begin
            ev       = EV_OVERFLOW;
            fin      = 1'b1;
            fin_base = cur_off + OFF_W'(2);
          end
        end
      end
      PH_BODY: begin
        part = PART_BODY;
        if (body_inc >= cur_flen) begin
          ev       = EV_BODY_END;
          body_end = 1'b1;
        end
      end
      default: begin
        part    = PART_IGNORED;
        out_off = '0;
      end
    endcase
  end

  assign go_body = (meth_nxt == METH_POST) && found_nxt && (flen_nxt != '0);
  assign last    = body_end || (fin && !go_body);

  // Next-state logic.
  always_comb begin
    phase_nxt      = cur_phase;
    off_nxt        = cur_off + 1'b1;
    prev_colon_nxt = cur_prev_colon;
    prefix_nxt     = cur_prefix;
    cnt_nxt        = cur_cnt;
    fields_nxt     = cur_fields;
    kpos_nxt       = cur_kpos;
    kmatch_nxt     = cur_kmatch;
    found_nxt      = cur_found;
    acc_nxt        = cur_acc;
    body_nxt       = cur_body;
    vstage_nxt     = cur_vstage;
    vneg_nxt       = cur_vneg;
    kend_nxt       = cur_kend;
    ver_nxt        = cur_ver;
    flen_nxt       = cur_flen;
    meth_nxt       = cur_meth;
    case (cur_phase)
      PH_METHOD: begin
        if (meth_end) begin
          meth_nxt       = decode_method(cur_prefix);
          phase_nxt      = PH_URI;
          prev_colon_nxt = 1'b0;
        end else begin
          for (int k = 0; k < 6; k++) begin
            if (cur_off == OFF_W'(k)) begin
              prefix_nxt[8*k +: 8] = cur_prefix[8*k +: 8] | q_data.data_byte;
            end
          end
          prev_colon_nxt = q_data.is_colon;
          if (hdr_last) begin
            meth_nxt = decode_method(cur_prefix);
          end
        end
      end
      PH_URI: begin
        if (q_data.is_space) begin
          phase_nxt      = PH_VERSION;
          ver_nxt        = '0;
          prev_colon_nxt = 1'b0;
        end else begin
          prev_colon_nxt = q_data.is_colon;
        end
      end
      PH_VERSION: begin
        if (cur_ver < VER_BYTES) begin
          ver_nxt        = cur_ver + 1'b1;
          prev_colon_nxt = q_data.is_colon;
        end else if (q_data.is_lf) begin
          prev_colon_nxt = 1'b0;
          phase_nxt      = PH_FIELDS;
          cnt_nxt        = '0;
          kpos_nxt       = '0;
          kmatch_nxt     = 1'b1;
          kend_nxt       = 1'b0;
          vstage_nxt     = VAL_NONE;
          vneg_nxt       = 1'b0;
          acc_nxt        = '0;
        end else begin
          prev_colon_nxt = q_data.is_colon;
        end
      end
      PH_FIELDS: begin
        if (q_data.is_lf) begin
          // A line end with at most one byte after the previous line end closes the header and changes nothing else.
          if (cur_cnt == '0) begin
            if (!cur_found && cur_kmatch && cur_kpos == NAME_LEN) begin
              found_nxt = 1'b1;
              flen_nxt  = value_res;
            end
            fields_nxt     = fields_inc;
            cnt_nxt        = 2'd2;
            prev_colon_nxt = 1'b0;
            kpos_nxt       = '0;
            kmatch_nxt     = 1'b1;
            kend_nxt       = 1'b0;
            vstage_nxt     = VAL_NONE;
            vneg_nxt       = 1'b0;
            acc_nxt        = '0;
          end
        end else begin
          if (cur_cnt != '0) begin
            cnt_nxt = cur_cnt - 1'b1;
          end
          if (cur_kmatch && cur_kpos < NAME_LEN) begin
            if (q_data.lower == name_char(cur_kpos)) begin
              kpos_nxt = cur_kpos + 1'b1;
            end else begin
              kmatch_nxt = 1'b0;
            end
          end
          if (sep) begin
            kend_nxt   = 1'b1;
            vstage_nxt = VAL_SKIP;
            vneg_nxt   = 1'b0;
            acc_nxt    = '0;
          end else if (cur_kend) begin
            case (cur_vstage)
              VAL_SKIP: begin
                if (!q_data.is_ws) begin
                  vstage_nxt = VAL_DIGITS;
                  if (q_data.is_minus) begin
                    vneg_nxt = 1'b1;
                  end else if (q_data.is_plus) begin
                    vneg_nxt = cur_vneg;
                  end else if (!q_data.is_digit) begin
                    vstage_nxt = VAL_NONE;
                  end else begin
                    acc_nxt = acc_step;
                  end
                end
              end
              VAL_DIGITS: begin
                if (q_data.is_digit) begin
                  acc_nxt = acc_step;
                end else begin
                  vstage_nxt = VAL_NONE;
                end
              end
              default: begin
                vstage_nxt = cur_vstage;
              end
            endcase
          end
          prev_colon_nxt = q_data.is_colon;
        end
      end
      PH_BODY: begin
        body_nxt = body_inc;
        if (body_inc >= cur_flen) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        off_nxt = cur_off;
      end
    endcase
    if (fin) begin
      off_nxt = fin_base;
      if (meth_nxt == METH_POST && found_nxt && flen_nxt != '0) begin
        phase_nxt = PH_BODY;
        body_nxt  = '0;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    res_data.offset         = 11'(out_off);
    res_data.part           = part;
    res_data.event_res      = ev;
    res_data.method         = meth_nxt;
    res_data.field_index    = 5'(fields_nxt);
    res_data.content_length = (meth_nxt == METH_POST && found_nxt) ? 11'(flen_nxt) : 11'd0;
    res_data.last           = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_METHOD;
      off_r        <= '0;
      prev_colon_r <= 1'b0;
      prefix_r     <= '0;
      cnt_r        <= '0;
      fields_r     <= '0;
      kpos_r       <= '0;
      kmatch_r     <= 1'b1;
      found_r      <= 1'b0;
      acc_r        <= '0;
      body_r       <= '0;
      vstage_r     <= VAL_NONE;
      vneg_r       <= 1'b0;
      kend_r       <= 1'b0;
      ver_r        <= '0;
      flen_r       <= '0;
      meth_r       <= METH_GET;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      off_r        <= off_nxt;
      prev_colon_r <= prev_colon_nxt;
      prefix_r     <= prefix_nxt;
      cnt_r        <= cnt_nxt;
      fields_r     <= fields_nxt;
      kpos_r       <= kpos_nxt;
      kmatch_r     <= kmatch_nxt;
      found_r      <= found_nxt;
      acc_r        <= acc_nxt;
      body_r       <= body_nxt;
      vstage_r     <= vstage_nxt;
      vneg_r       <= vneg_nxt;
      kend_r       <= kend_nxt;
      ver_r        <= ver_nxt;
      flen_r       <= flen_nxt;
      meth_r       <= meth_nxt;
    end
  end

endmodule

// ===== design/http_request_header_parser_core.sv =====
// Byte-serial HTTP/1.1 request header parser. Each accepted byte produces exactly one
// result transaction that tags the byte with its buffer offset and request part, reports
// method, URI, version, field, header and body boundaries, and carries the decoded method,
// the count of completed header fields and the Content-Length of a POST. The block takes
// one byte per clock cycle while the result queue is not held full; that rate is set by the
// parse state update in the back end. A byte goes through the input register, a two-entry
// queue and the state update into a two-entry result queue, where its result is visible.
// Setting start_req on a byte starts a new request at offset 0; no clearing pass is needed.
module http_request_header_parser_core #(
  parameter int HEADER_BYTES = 1024,
  parameter int BODY_BYTES   = 1024,
  parameter int MAX_FIELDS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hrp_pkg::in_item_t  in_data,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output hrp_pkg::out_item_t out_data
);

  import hrp_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  logic      fq_push, fq_full, fq_empty, fq_pop;
  cls_item_t fq_wr_data, fq_rd_data;
  logic      rq_push, rq_full;
  out_item_t rq_wr_data;

  hrp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (fq_push),
    .q_data  (fq_wr_data),
    .q_full  (fq_full)
  );

  hrp_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_wr_data),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data (fq_rd_data),
    .empty   (fq_empty)
  );

  hrp_back #(
    .HEADER_BYTES (HEADER_BYTES),
    .BODY_BYTES   (BODY_BYTES),
    .MAX_FIELDS   (MAX_FIELDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (fq_rd_data),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_data (rq_wr_data)
  );

  hrp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_wr_data),
    .full    (rq_full),
    .pop     (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule
